// ===== rtl/word_multiply_divide_unit_top_assert.svh =====
// Assertion macros used by the port-level checker file.
`ifndef WORD_MULTIPLY_DIVIDE_UNIT_TOP_ASSERT_SVH
`define WORD_MULTIPLY_DIVIDE_UNIT_TOP_ASSERT_SVH
// implication checked on every edge outside reset
`define WMDU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define WMDU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/wmdu_pkg.sv =====
// Shared types, codes and constants of the multiply and divide unit.
package wmdu_pkg;
    localparam int WORD_W = 16;
    localparam int OP_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STAGES = 32;

    localparam logic [OP_W-1:0] OP_MULU = 3'd0;
    localparam logic [OP_W-1:0] OP_MULS = 3'd1;
    localparam logic [OP_W-1:0] OP_DIVU = 3'd2;
    localparam logic [OP_W-1:0] OP_DIVS = 3'd3;
    localparam logic [OP_W-1:0] OP_MULT = 3'd4;

    localparam logic [31:0] MIN_DIVIDEND = 32'h8000_0000;

    // classified item handed from front to back
    typedef struct packed {
        logic                is_mul;
        logic                is_div;
        logic                signed_op;
        logic                trunc;
        logic [WORD_W-1:0]   a;
        logic [WORD_W-1:0]   b;
        logic [2*WORD_W-1:0] dividend;
    } work_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_low;
        logic [WORD_W-1:0] result_high;
        logic divide_error;
        logic flags_written;
        logic carry_flag;
        logic overflow_flag;
        logic sign_flag;
        logic zero_flag;
        logic parity_flag;
        logic aux_flag;
    } result_t;
endpackage

// ===== rtl/word_multiply_divide_unit_top.sv =====
// Top level of the 16-bit multiply and divide unit.
// Usage:
//   Input side is a queue: drive the operands and raise push; the item is
//   taken on an edge where push is high and full is low.
//   Result side is a queue: while empty is low the oldest result sits on the
//   result ports; raise pop to take it.
//   Path: from the accepting edge an item passes the operand stage, the
//   back-end input register, 32 divide stages shared with the multiplier,
//   then the queue write, after which empty falls. Throughput: one item per
//   cycle while full is low; the 32-stage bit-per-cycle divider sets the
//   latency, not the rate. Stall: when the receiver stops popping, results
//   collect in the output queue; full rises once the queue cannot hold every
//   item in flight, while the pipeline itself never stalls.
//   Reset: rst_n low clears all valid bits and queue pointers; nothing is
//   held over, and full and empty read low and high afterwards.
module word_multiply_divide_unit_top #(
    parameter int QDEPTH = wmdu_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [wmdu_pkg::OP_W-1:0]   operation,
    input  logic [wmdu_pkg::WORD_W-1:0] acc_low,
    input  logic [wmdu_pkg::WORD_W-1:0] acc_high,
    input  logic [wmdu_pkg::WORD_W-1:0] source_value,
    input  logic [wmdu_pkg::WORD_W-1:0] factor_value,
    output logic                        empty,
    input  logic                        pop,
    output logic [wmdu_pkg::WORD_W-1:0] result_low,
    output logic [wmdu_pkg::WORD_W-1:0] result_high,
    output logic                        divide_error,
    output logic                        flags_written,
    output logic                        carry_flag,
    output logic                        overflow_flag,
    output logic                        sign_flag,
    output logic                        zero_flag,
    output logic                        parity_flag,
    output logic                        aux_flag
);
    import wmdu_pkg::*;
    localparam int INFLIGHT = DIV_STAGES + 2;
    localparam int QD = QDEPTH + INFLIGHT;
    localparam int CW = $clog2(QD+1);

    logic    f_ready, f_valid, b_valid;
    work_t   f_work;
    result_t b_res, q_res;
    logic [CW-1:0] q_cnt;
    logic [$clog2(INFLIGHT+1)-1:0] fly_reg;
    logic    take, retire;

    // credit check: every item in flight has a queue slot reserved
    assign full = !f_ready || ((32'(q_cnt) + 32'(fly_reg)) >= 32'(QD));
    assign take = push && !full;
    assign retire = b_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fly_reg <= '0;
        end
        else
        begin
            fly_reg <= fly_reg + (take ? 1'b1 : 1'b0) - (retire ? 1'b1 : 1'b0);
        end
    end

    wmdu_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(take), .in_ready(f_ready),
        .operation(operation), .acc_low(acc_low), .acc_high(acc_high),
        .source_value(source_value), .factor_value(factor_value),
        .out_valid(f_valid), .out_ready(1'b1), .out_work(f_work)
    );

    wmdu_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid), .in_work(f_work),
        .advance(1'b1), .out_valid(b_valid), .out_result(b_res)
    );

    wmdu_queue #(.DEPTH(QD)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(b_valid), .wdata(b_res),
        .pop(pop), .empty(empty), .rdata(q_res), .count(q_cnt)
    );

    assign result_low    = q_res.result_low;
    assign result_high   = q_res.result_high;
    assign divide_error  = q_res.divide_error;
    assign flags_written = q_res.flags_written;
    assign carry_flag    = q_res.carry_flag;
    assign overflow_flag = q_res.overflow_flag;
    assign sign_flag     = q_res.sign_flag;
    assign zero_flag     = q_res.zero_flag;
    assign parity_flag   = q_res.parity_flag;
    assign aux_flag      = q_res.aux_flag;
endmodule

// ===== rtl/wmdu_ram.sv =====
// Generic single-write, single-read RAM with registered read.
module wmdu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/wmdu_front.sv =====
// Front end: decode the operation and capture operands into a work item.
module wmdu_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [wmdu_pkg::OP_W-1:0]      operation,
    input  logic [wmdu_pkg::WORD_W-1:0]    acc_low,
    input  logic [wmdu_pkg::WORD_W-1:0]    acc_high,
    input  logic [wmdu_pkg::WORD_W-1:0]    source_value,
    input  logic [wmdu_pkg::WORD_W-1:0]    factor_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output wmdu_pkg::work_t                out_work
);
    import wmdu_pkg::*;

    logic  valid_reg;
    work_t work_reg;
    work_t work_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_comb
    begin
        work_next = '0;
        work_next.dividend = {acc_high, acc_low};
        work_next.a = acc_low;
        work_next.b = source_value;
        case (operation)
            OP_MULU: work_next.is_mul = 1'b1;
            OP_MULS:
            begin
                work_next.is_mul = 1'b1;
                work_next.signed_op = 1'b1;
            end
            OP_MULT:
            begin
                work_next.is_mul = 1'b1;
                work_next.signed_op = 1'b1;
                work_next.trunc = 1'b1;
                work_next.a = factor_value;
            end
            OP_DIVU: work_next.is_div = 1'b1;
            OP_DIVS:
            begin
                work_next.is_div = 1'b1;
                work_next.signed_op = 1'b1;
            end
            default: work_next.is_mul = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg <= work_next;
        end
    end
endmodule

// ===== rtl/wmdu_back.sv =====
// Back end: pipelined multiply and restoring divide, one bit per stage.
module wmdu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  wmdu_pkg::work_t   in_work,
    input  logic              advance,
    output logic              out_valid,
    output wmdu_pkg::result_t out_result
);
    import wmdu_pkg::*;

    // per-stage context of the pipeline
    typedef struct packed {
        logic        is_mul;
        logic        is_div;
        logic        signed_op;
        logic        trunc;
        logic        err;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] prod;
        logic [31:0] sh;
        logic [15:0] prem;
        logic [16:0] dvs;
    } stage_t;

    stage_t st_reg [DIV_STAGES+1];
    logic   vld_reg [DIV_STAGES+1];
    stage_t s0;
    logic signed [16:0] ma, mb;
    logic signed [33:0] pfull;
    logic [31:0] nmag;
    logic [15:0] dmag;
    logic        nneg, dneg;

    always_comb
    begin
        s0 = '0;
        s0.is_mul = in_work.is_mul;
        s0.is_div = in_work.is_div;
        s0.signed_op = in_work.signed_op;
        s0.trunc = in_work.trunc;
        ma = in_work.signed_op ? {in_work.a[15], in_work.a} : {1'b0, in_work.a};
        mb = in_work.signed_op ? {in_work.b[15], in_work.b} : {1'b0, in_work.b};
        pfull = ma * mb;
        s0.prod = pfull[31:0];
        nneg = in_work.signed_op && in_work.dividend[31];
        dneg = in_work.signed_op && in_work.b[15];
        nmag = nneg ? (~in_work.dividend + 32'd1) : in_work.dividend;
        dmag = dneg ? (~in_work.b + 16'd1) : in_work.b;
        s0.sh = nmag;
        s0.dvs = {1'b0, dmag};
        s0.neg_q = nneg ^ dneg;
        s0.neg_r = nneg;
        s0.err = in_work.is_div && ((in_work.b == '0)
            || (in_work.signed_op && in_work.dividend == MIN_DIVIDEND));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= s0;
        end
    end

    // each stage shifts one dividend bit out of sh into the partial remainder
    // and shifts the new quotient bit into the bottom of sh
    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_div
        stage_t prev, nxt;
        logic [16:0] part;
        always_comb
        begin
            prev = st_reg[g-1];
            nxt = prev;
            part = {prev.prem, prev.sh[31]};
            nxt.sh = {prev.sh[30:0], 1'b0};
            if (part >= prev.dvs)
            begin
                nxt.sh[0] = 1'b1;
                nxt.prem = 16'(part - prev.dvs);
            end
            else
            begin
                nxt.prem = part[15:0];
            end
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[g] <= nxt;
            end
        end
    end

    // sh holds the quotient magnitude, prem the remainder magnitude
    stage_t fin;
    logic [31:0] q_mag;
    logic [15:0] r_mag, q16, r16;
    logic        fit;

    always_comb
    begin
        fin = st_reg[DIV_STAGES];
        out_result = '0;
        q_mag = fin.sh;
        r_mag = fin.prem;
        q16 = fin.neg_q ? (~q_mag[15:0] + 16'd1) : q_mag[15:0];
        r16 = fin.neg_r ? (~r_mag + 16'd1) : r_mag;
        fit = (q_mag[31:16] == 16'd0) && (!fin.signed_op ||
              (fin.neg_q ? (q_mag[15:0] <= 16'h8000) : !q_mag[15]));
        if (fin.is_mul)
        begin
            out_result.result_low = fin.prod[15:0];
            out_result.result_high = fin.trunc ? 16'd0 : fin.prod[31:16];
            out_result.flags_written = 1'b1;
            out_result.carry_flag = fin.signed_op
                ? (fin.prod[31:15] != {17{fin.prod[15]}})
                : (fin.prod[31:16] != 16'd0);
            out_result.overflow_flag = out_result.carry_flag;
            out_result.sign_flag = fin.prod[15];
            out_result.zero_flag = (fin.prod[15:0] == 16'd0);
            out_result.parity_flag = ~^fin.prod[7:0];
        end
        else if (fin.is_div)
        begin
            if (fin.err || !fit)
            begin
                out_result.divide_error = 1'b1;
            end
            else
            begin
                out_result.result_low = q16;
                out_result.result_high = r16;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES];
endmodule

// ===== rtl/wmdu_queue.sv =====
// Result queue: RAM-backed FIFO with a registered output word.
module wmdu_queue #(
    parameter int DEPTH = wmdu_pkg::QUEUE_DEPTH + wmdu_pkg::DIV_STAGES + 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wmdu_pkg::result_t wdata,
    input  logic              pop,
    output logic              empty,
    output wmdu_pkg::result_t rdata,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import wmdu_pkg::*;
    localparam int AW = $clog2(DEPTH);
    localparam int W = $bits(result_t);

    logic [AW-1:0] wp_reg, rp_reg, rp_next;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;
    logic do_pop;
    result_t ram_rdata;
    result_t byp_data_reg;
    logic    byp_reg;

    assign do_pop = pop && (cnt_reg != '0);
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
    // read ahead at the head the queue will have after this edge
    assign rp_next = do_pop ? ((rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1) : rp_reg;
    // a word written onto that head is not seen by the read yet: take it from the side
    assign rdata = byp_reg ? byp_data_reg : ram_rdata;

    wmdu_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(push), .waddr(wp_reg), .wdata(wdata),
        .raddr(rp_next), .rdata(ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            byp_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= push && (wp_reg == rp_next);
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            rp_reg <= rp_next;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
        end
    end
endmodule

// ===== rtl/wmdu_checker.sv =====
// Port-level checker for the multiply and divide unit, bound to the top level.
`include "word_multiply_divide_unit_top_assert.svh"
module wmdu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        divide_error,
    input logic        flags_written,
    input logic        carry_flag,
    input logic        overflow_flag,
    input logic        aux_flag,
    input logic [15:0] result_low,
    input logic [15:0] result_high
);
    `WMDU_ASSERT_IMP(a_ovf_eq_cf, clk, rst_n, !empty, carry_flag == overflow_flag)
    `WMDU_ASSERT_IMP(a_aux_zero, clk, rst_n, !empty, !aux_flag)
    `WMDU_ASSERT_IMP(a_err_clean, clk, rst_n, !empty && divide_error,
        !flags_written && result_low == 16'd0 && result_high == 16'd0)
    `WMDU_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(result_low) && $stable(result_high))
endmodule

bind word_multiply_divide_unit_top wmdu_checker u_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .divide_error(divide_error), .flags_written(flags_written),
    .carry_flag(carry_flag), .overflow_flag(overflow_flag), .aux_flag(aux_flag),
    .result_low(result_low), .result_high(result_high)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the 16-bit multiply and divide unit.
`timescale 1ns / 1ps

import wmdu_pkg::*;

typedef struct {
    logic [15:0] lo;
    logic [15:0] hi;
    logic        derr;
    logic        fw;
    logic        cf;
    logic        of;
    logic        sf;
    logic        zf;
    logic        pf;
    logic        af;
} muldiv_out_t;

class muldiv_scoreboard;
    muldiv_out_t pending[$];
    int          errors;
    int          checked;
    int          div_faults;

    function muldiv_out_t compute(logic [2:0] op, logic [15:0] alo, logic [15:0] ahi,
                                  logic [15:0] src, logic [15:0] fac);
        muldiv_out_t r;
        logic [31:0] prod;
        logic [31:0] num;
        longint      sn;
        longint      sd;
        longint      sq;
        longint      sr;
        logic        wide;
        r = '{default: 0};
        wide = 0;
        if (op == OP_MULU)
        begin
            prod = {16'd0, alo} * {16'd0, src};
            r.lo = prod[15:0];
            r.hi = prod[31:16];
            wide = (prod[31:16] != 0);
        end
        else if (op == OP_MULS || op == OP_MULT)
        begin
            sn = longint'($signed(op == OP_MULS ? alo : fac));
            sd = longint'($signed(src));
            sq = sn * sd;
            prod = sq[31:0];
            r.lo = prod[15:0];
            r.hi = (op == OP_MULS) ? prod[31:16] : 16'd0;
            wide = (sq != longint'($signed(prod[15:0])));
        end
        else if (op == OP_DIVU)
        begin
            num = {ahi, alo};
            if (src == 0 || num / src > 32'hFFFF)
            begin
                r.derr = 1;
            end
            else
            begin
                r.lo = 16'(num / src);
                r.hi = 16'(num % src);
            end
        end
        else if (op == OP_DIVS)
        begin
            num = {ahi, alo};
            sn = longint'($signed(num));
            sd = longint'($signed(src));
            if (num == MIN_DIVIDEND || sd == 0)
            begin
                r.derr = 1;
            end
            else
            begin
                sq = sn / sd;
                sr = sn % sd;
                if (sq < -32768 || sq > 32767) r.derr = 1;
                else
                begin
                    r.lo = sq[15:0];
                    r.hi = sr[15:0];
                end
            end
        end
        if (op == OP_MULU || op == OP_MULS || op == OP_MULT)
        begin
            r.fw = 1;
            r.cf = wide;
            r.of = wide;
            r.sf = r.lo[15];
            r.zf = (r.lo == 0);
            r.pf = ~^r.lo[7:0];
        end
        return r;
    endfunction

    function void note_item(logic [2:0] op, logic [15:0] alo, logic [15:0] ahi,
                            logic [15:0] src, logic [15:0] fac);
        muldiv_out_t r;
        r = compute(op, alo, ahi, src, fac);
        if (r.derr) div_faults++;
        pending.push_back(r);
    endfunction

    function void report(string what, int got, int want);
        $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
        errors++;
    endfunction

    function void check_result(muldiv_out_t got);
        muldiv_out_t w;
        checked++;
        if (pending.size() == 0)
        begin
            $display("MISMATCH: unexpected result %0d", checked);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (got.lo !== w.lo) report("result_low", got.lo, w.lo);
        if (got.hi !== w.hi) report("result_high", got.hi, w.hi);
        if (got.derr !== w.derr) report("divide_error", got.derr, w.derr);
        if (got.fw !== w.fw) report("flags_written", got.fw, w.fw);
        if (got.cf !== w.cf) report("carry_flag", got.cf, w.cf);
        if (got.of !== w.of) report("overflow_flag", got.of, w.of);
        if (got.sf !== w.sf) report("sign_flag", got.sf, w.sf);
        if (got.zf !== w.zf) report("zero_flag", got.zf, w.zf);
        if (got.pf !== w.pf) report("parity_flag", got.pf, w.pf);
        if (got.af !== w.af) report("aux_flag", got.af, w.af);
    endfunction
endclass

module testbench;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        pop = 0;
    logic [2:0]  operation = 0;
    logic [15:0] acc_low = 0;
    logic [15:0] acc_high = 0;
    logic [15:0] source_value = 0;
    logic [15:0] factor_value = 0;
    logic        full;
    logic        empty;
    logic [15:0] result_low;
    logic [15:0] result_high;
    logic        divide_error;
    logic        flags_written;
    logic        carry_flag;
    logic        overflow_flag;
    logic        sign_flag;
    logic        zero_flag;
    logic        parity_flag;
    logic        aux_flag;

    muldiv_scoreboard sb;
    bit  hold_off = 0;
    int  idle_cycles = 0;
    int  sent = 0;
    int  full_stalls = 0;

    localparam int WATCHDOG_LIMIT = 4000;

    word_multiply_divide_unit_top dut (.*);

    always #5 clk = ~clk;

    // push stays high after an item is taken; drop it only when a gap follows
    task automatic send_item(logic [2:0] op, logic [15:0] alo, logic [15:0] ahi,
                             logic [15:0] src, logic [15:0] fac);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (sent % 100 < 30 || hold_off) gap = 0;
        if (gap > 0)
        begin
            push <= 0;
            repeat (gap) @(posedge clk);
        end
        push <= 1;
        operation <= op;
        acc_low <= alo;
        acc_high <= ahi;
        source_value <= src;
        factor_value <= fac;
        @(posedge clk);
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        sb.note_item(op, alo, ahi, src, fac);
        sent++;
    endtask

    task automatic send_random();
        logic [2:0]  op;
        logic [15:0] alo;
        logic [15:0] ahi;
        logic [15:0] src;
        logic [15:0] fac;
        op = $urandom_range(0, 20) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        alo = $urandom;
        ahi = $urandom;
        src = $urandom;
        fac = $urandom;
        // keep most divisions in range so the quotient path gets exercised
        if ((op == OP_DIVU || op == OP_DIVS) && $urandom_range(0, 3) != 0)
        begin
            if (op == OP_DIVU) ahi = src == 0 ? 0 : 16'($urandom_range(0, src - 1));
            else
            begin
                ahi = {16{alo[15]}};
                if ($urandom_range(0, 1))
                begin
                    src = 16'($urandom_range(0, 255)) | 16'h0100;
                    ahi = ahi ^ 16'($urandom_range(0, 15)) & 16'h0000;
                end
            end
        end
        case ($urandom_range(0, 9))
            0: src = 0;
            1: src = 16'hFFFF;
            2: src = 16'h8000;
            default: ;
        endcase
        send_item(op, alo, ahi, src, fac);
    endtask

    // result side: random stalls, with one long hold-off to fill the queue
    initial
    begin
        int gap;
        muldiv_out_t got;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
            if (hold_off) gap = 0;
            if (gap > 0 || hold_off)
            begin
                pop <= 0;
                repeat (gap) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            pop <= 1;
            @(posedge clk);
            while (empty) @(posedge clk);
            got.lo = result_low;
            got.hi = result_high;
            got.derr = divide_error;
            got.fw = flags_written;
            got.cf = carry_flag;
            got.of = overflow_flag;
            got.sf = sign_flag;
            got.zf = zero_flag;
            got.pf = parity_flag;
            got.af = aux_flag;
            sb.check_result(got);
        end
    end

    // watchdog: count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d items pending", sb.pending.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, every operation, the divide faults
        send_item(OP_MULU, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_item(OP_MULU, 16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF);
        send_item(OP_MULU, 16'h00FF, 16'h0000, 16'h0001, 16'h0000);
        send_item(OP_MULS, 16'h8000, 16'h0000, 16'h8000, 16'h0000);
        send_item(OP_MULS, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
        send_item(OP_MULS, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000);
        send_item(OP_MULT, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
        send_item(OP_MULT, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF);
        send_item(OP_MULT, 16'h0000, 16'h0000, 16'h0003, 16'h0005);
        send_item(OP_DIVU, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_DIVU, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
        send_item(OP_DIVU, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h0000);
        send_item(OP_DIVU, 16'h0007, 16'h0000, 16'h0003, 16'h0000);
        send_item(OP_DIVS, 16'h0000, 16'h8000, 16'h0001, 16'h0000);
        send_item(OP_DIVS, 16'h0000, 16'h8000, 16'hFFFF, 16'h0000);
        send_item(OP_DIVS, 16'h0005, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_DIVS, 16'hFFF9, 16'hFFFF, 16'h0002, 16'h0000);
        send_item(OP_DIVS, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_item(OP_DIVS, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000);
        send_item(OP_DIVS, 16'h7FFF, 16'h0000, 16'h0001, 16'h0000);
        send_item(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(3'd6, 16'h1234, 16'h5678, 16'h0001, 16'h0002);
        send_item(3'd7, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // long receiver hold-off while items keep coming; more items than
        // the block holds, so the sender outlasts the hold-off
        fork
            begin
                hold_off = 1;
                repeat (150) @(posedge clk);
                hold_off = 0;
            end
            repeat (60) send_random();
        join

        repeat (440) send_random();
        push <= 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Checked %0d results from %0d items, %0d divide faults, %0d cycles stalled on full",
                 sb.checked, sent, sb.div_faults, full_stalls);
        if (sb.errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
